>>> hdl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared constants and types of the heap sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

   // Default store capacity and stored word width
   localparam int MAX_ITEMS_DEF  = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // Width of the value fields on the stream ports
   localparam int FIELD_W = 32;

   // Control of one result beat handed from the sequencer to the output stage
   typedef struct packed {
      logic valid;
      logic final_res;
      logic overflow;
   } emit_type;

endpackage

>>> hdl/heap_sort_engine.sv
// ----------------------------------------------------------------------------
// heap_sort_engine
// Collects a set of signed values and returns it in ascending order.
// ----------------------------------------------------------------------------
// Values arrive one per beat and are written to a two-read-port RAM; a beat
// with tlast closes the set. Beats past MAX_ITEMS are dropped and every result
// of that set then carries tuser = 1. The engine takes one beat per cycle
// while loading, then drops req_tready while it heapsorts: a bottom-up build
// of n/2 sifts and n-1 root extractions, each sift-down level reading both
// children together and writing one value back, plus reads that fetch the
// start values and a final write that places the sifted value. Results are
// then read out one by one, each through a store read and a hand-over to
// the output register. The last result is marked by rsp_tlast; the next set
// may be loaded while it waits to be taken.
// ----------------------------------------------------------------------------
module heap_sort_engine import hse_pkg::*; #(
   parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // input stream
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [FIELD_W-1:0] req_tdata,   // [31:0] value
   input  logic               req_tlast,
   // result stream
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [FIELD_W-1:0] rsp_tdata,   // [31:0] sorted_value
   output logic               rsp_tlast,
   output logic [0:0]         rsp_tuser    // [0] overflow
);

   logic [DATA_WIDTH-1:0] load_data;
   logic [DATA_WIDTH-1:0] emit_data;
   logic [FIELD_W-1:0]    emit_word;
   emit_type              emit;
   logic                  slot_free;

   logic               out_valid_ff, out_valid_in;
   logic [FIELD_W-1:0] out_data_ff;
   logic               out_last_ff;
   logic               out_ovf_ff;

   // width conversion between port fields and stored words
   generate
      if (DATA_WIDTH <= FIELD_W) begin : g_narrow
         assign load_data = req_tdata[DATA_WIDTH-1:0];
         assign emit_word = FIELD_W'(emit_data);
      end else begin : g_wide
         assign load_data = DATA_WIDTH'($signed(req_tdata));
         assign emit_word = emit_data[FIELD_W-1:0];
      end
   endgenerate

   hse_ctrl #(
      .MAX_ITEMS  (MAX_ITEMS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_tvalid),
      .load_ready (req_tready),
      .load_data  (load_data),
      .load_last  (req_tlast),
      .slot_free  (slot_free),
      .emit       (emit),
      .emit_data  (emit_data)
   );

   // output register
   assign slot_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         out_data_ff <= emit_word;
         out_last_ff <= emit.final_res;
         out_ovf_ff  <= emit.overflow;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_ovf_ff;

endmodule

>>> hdl/hse_ram.sv
// ----------------------------------------------------------------------------
// hse_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

>>> hdl/hse_ctrl.sv
// ----------------------------------------------------------------------------
// hse_ctrl
// Load, heap build, extraction and read-out sequencer around the value store.
// ----------------------------------------------------------------------------
module hse_ctrl import hse_pkg::*; #(
   parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // load side
   input  logic                  load_valid,
   output logic                  load_ready,
   input  logic [DATA_WIDTH-1:0] load_data,
   input  logic                  load_last,
   // result side
   input  logic                  slot_free,
   output emit_type              emit,
   output logic [DATA_WIDTH-1:0] emit_data
);

   localparam int AW    = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IW    = AW + 2;

   localparam logic [2:0] S_LOAD     = 3'd0;
   localparam logic [2:0] S_BUILD_RD = 3'd1;
   localparam logic [2:0] S_BUILD_V  = 3'd2;
   localparam logic [2:0] S_SIFT     = 3'd3;
   localparam logic [2:0] S_EXT_RD   = 3'd4;
   localparam logic [2:0] S_EXT_SWAP = 3'd5;
   localparam logic [2:0] S_EMIT_RD  = 3'd6;
   localparam logic [2:0] S_EMIT_WT  = 3'd7;

   localparam logic PH_BUILD   = 1'b0;
   localparam logic PH_EXTRACT = 1'b1;

   // control state
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             phase_ff, phase_in;
   // sort bookkeeping
   logic [CNT_W-1:0] n_ff, n_in;
   logic             ovf_ff, ovf_in;
   logic [AW-1:0]    bnode_ff, bnode_in;
   logic [AW-1:0]    j_ff, j_in;
   logic [AW-1:0]    k_ff, k_in;
   logic [AW-1:0]    node_ff, node_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [DATA_WIDTH-1:0] v_ff, v_in;

   // store ports
   logic                  we;
   logic [AW-1:0]         waddr;
   logic [DATA_WIDTH-1:0] wdata;
   logic [AW-1:0]         raddr_a, raddr_b;
   logic [DATA_WIDTH-1:0] rd_a, rd_b;

   // sift step terms
   logic [IW-1:0]         lc, rc, sel_lc, sel_rc;
   logic                  l_ok, r_ok, take_l, take_r, moved;
   logic [DATA_WIDTH-1:0] top_val, sel_val;
   logic [AW-1:0]         sel;
   logic                  room;
   logic [CNT_W-1:0]      n_new;
   logic                  ovf_new;
   logic                  is_final;

   hse_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock     (clock),
      .wr_en     (we),
      .wr_addr   (waddr),
      .wr_data   (wdata),
      .rd_addr_a (raddr_a),
      .rd_addr_b (raddr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // children of the current node and the larger-of-three pick
   always_comb begin
      lc      = {1'b0, node_ff, 1'b1};
      rc      = lc + IW'(1);
      l_ok    = lc < IW'(size_ff);
      r_ok    = rc < IW'(size_ff);
      take_l  = l_ok && ($signed(rd_a) > $signed(v_ff));
      top_val = take_l ? rd_a : v_ff;
      take_r  = r_ok && ($signed(rd_b) > $signed(top_val));
      moved   = take_l || take_r;
      sel     = take_r ? rc[AW-1:0] : lc[AW-1:0];
      sel_val = take_r ? rd_b : rd_a;
      sel_lc  = {1'b0, sel, 1'b1};
      sel_rc  = sel_lc + IW'(1);
   end

   // load bookkeeping
   always_comb begin
      room     = count_ff < CNT_W'(MAX_ITEMS);
      n_new    = room ? count_ff + CNT_W'(1) : count_ff;
      ovf_new  = drop_ff || !room;
      is_final = (CNT_W'(k_ff) + CNT_W'(1)) == n_ff;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      drop_in    = drop_ff;
      phase_in   = phase_ff;
      n_in       = n_ff;
      ovf_in     = ovf_ff;
      bnode_in   = bnode_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      node_in    = node_ff;
      size_in    = size_ff;
      v_in       = v_ff;
      we         = 1'b0;
      waddr      = count_ff[AW-1:0];
      wdata      = load_data;
      raddr_a    = lc[AW-1:0];
      raddr_b    = rc[AW-1:0];
      load_ready = 1'b0;
      emit       = '0;
      emit_data  = rd_a;

      case (state_ff)
         S_LOAD: begin
            load_ready = 1'b1;
            if (load_valid) begin
               we = room;
               if (load_last) begin
                  n_in     = n_new;
                  ovf_in   = ovf_new;
                  count_in = '0;
                  drop_in  = 1'b0;
                  k_in     = '0;
                  if (n_new == CNT_W'(1)) begin
                     state_in = S_EMIT_RD;
                  end else begin
                     phase_in = PH_BUILD;
                     bnode_in = AW'(n_new >> 1) - AW'(1);
                     state_in = S_BUILD_RD;
                  end
               end else begin
                  count_in = n_new;
                  drop_in  = ovf_new;
               end
            end
         end

         // fetch the subtree root of the next bottom-up sift
         S_BUILD_RD: begin
            raddr_a  = bnode_ff;
            node_in  = bnode_ff;
            size_in  = n_ff;
            state_in = S_BUILD_V;
         end

         // hold the root value, fetch its children
         S_BUILD_V: begin
            v_in     = rd_a;
            state_in = S_SIFT;
         end

         // one level of sift-down per cycle, the sifted value rides in v_ff
         S_SIFT: begin
            we = 1'b1;
            waddr = node_ff;
            if (moved) begin
               wdata   = sel_val;
               node_in = sel;
               raddr_a = sel_lc[AW-1:0];
               raddr_b = sel_rc[AW-1:0];
            end else begin
               wdata = v_ff;
               if (phase_ff == PH_BUILD) begin
                  if (bnode_ff == '0) begin
                     phase_in = PH_EXTRACT;
                     j_in     = AW'(n_ff - CNT_W'(1));
                     state_in = S_EXT_RD;
                  end else begin
                     bnode_in = bnode_ff - AW'(1);
                     state_in = S_BUILD_RD;
                  end
               end else if (j_ff == AW'(1)) begin
                  k_in     = '0;
                  state_in = S_EMIT_RD;
               end else begin
                  j_in     = j_ff - AW'(1);
                  state_in = S_EXT_RD;
               end
            end
         end

         // fetch root and last live entry
         S_EXT_RD: begin
            raddr_a  = '0;
            raddr_b  = j_ff;
            node_in  = '0;
            size_in  = CNT_W'(j_ff);
            state_in = S_EXT_SWAP;
         end

         // root goes to the end, old last entry sifts down from the root
         S_EXT_SWAP: begin
            we       = 1'b1;
            waddr    = j_ff;
            wdata    = rd_a;
            v_in     = rd_b;
            state_in = S_SIFT;
         end

         // read out in ascending order once the output slot frees up
         S_EMIT_RD: begin
            raddr_a = k_ff;
            if (slot_free) begin
               state_in = S_EMIT_WT;
            end
         end

         S_EMIT_WT: begin
            emit.valid     = 1'b1;
            emit.final_res = is_final;
            emit.overflow  = ovf_ff;
            if (is_final) begin
               state_in = S_LOAD;
            end else begin
               k_in     = k_ff + AW'(1);
               state_in = S_EMIT_RD;
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         phase_ff <= PH_BUILD;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      ovf_ff   <= ovf_in;
      bnode_ff <= bnode_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      node_ff  <= node_in;
      size_ff  <= size_in;
      v_ff     <= v_in;
   end

endmodule

>>> bench/heap_sort_engine_tb.sv
// ----------------------------------------------------------------------------
// heap_sort_engine_tb
// Self-checking bench for the heap sort engine.
// ----------------------------------------------------------------------------
// Sets of signed values are streamed in, and each set is closed by a beat
// with tlast. A software copy of the engine keeps the values of the open set.
// When tlast is taken, it sorts them and queues the result beats it expects:
// ascending values, tlast on the final one, and the overflow flag on every
// beat of a set that ran past capacity. A monitor compares every result beat
// with the oldest expected one. The run covers directed corner sets, full and
// overflowing sets, and random sets under several idle/stall mixes. It also
// has a long receiver hold-off that backs the engine up into its input.
// ----------------------------------------------------------------------------
module heap_sort_engine_tb import hse_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY      = MAX_ITEMS_DEF;
   localparam int IDLE_LIMIT    = 20000;  // cycles with no beat on either side
   localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
   localparam int SETTLE_CYCLES = 50;     // quiet time after the last result
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [FIELD_W-1:0] value;
      logic               final_res;
      logic               overflow;
   } sorted_beat_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [FIELD_W-1:0] req_tdata  = '0;
   logic               req_tlast  = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [FIELD_W-1:0] rsp_tdata;
   logic               rsp_tlast;
   logic [0:0]         rsp_tuser;

   // predictor state: the open set and the beats still owed by the engine
   int signed          open_set_q[$];
   bit                 set_overflowed = 1'b0;
   sorted_beat_type    sorted_expect_q[$];

   int                 mismatch_count = 0;
   int                 idle_cycles    = 0;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   bit                 hold_rsp       = 1'b0;

   heap_sort_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] value
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] sorted_value
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)    // [0] overflow
   );

   always #5 clock = ~clock;

   // Set bookkeeping: store or drop the value, and on tlast sort the set
   // ascending and queue one expected beat per held value.
   function automatic void load_and_sort(logic [FIELD_W-1:0] value, logic last);
      int signed       sorted_q[$];
      int              pos;
      sorted_beat_type beat;
      if (open_set_q.size() < CAPACITY) open_set_q.insert(open_set_q.size(), int'(value));
      else set_overflowed = 1'b1;
      if (!last) return;
      // insertion sort, signed compare
      foreach (open_set_q[i]) begin
         pos = sorted_q.size();
         while (pos > 0 && sorted_q[pos-1] > open_set_q[i]) pos--;
         sorted_q.insert(pos, open_set_q[i]);
      end
      foreach (sorted_q[k]) begin
         beat.value     = sorted_q[k];
         beat.final_res = (k == sorted_q.size() - 1);
         beat.overflow  = set_overflowed;
         sorted_expect_q.insert(sorted_expect_q.size(), beat);
      end
      open_set_q.delete();
      set_overflowed = 1'b0;
   endfunction

   function automatic void note_error(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
   endfunction

   // Half wide random values, the rest extremes and a narrow band near zero
   // so that duplicates and sign changes show up often.
   function automatic logic [FIELD_W-1:0] pick_value();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2, 3:    return 32'(int'($urandom_range(8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   // One input beat. It idles at random, then holds valid until the beat is taken.
   task automatic send_beat(input logic [FIELD_W-1:0] value, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      load_and_sort(value, last);
   endtask

   task automatic send_set(input int count);
      for (int i = 0; i < count; i++) send_beat(pick_value(), i == count - 1);
   endtask

   // Stop offering beats until every owed result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sorted_expect_q.size() != 0) @(posedge clock);
   endtask

   // Receiver side: random stalls, or a forced hold-off
   always @(negedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each taken result beat with the oldest expectation
   always @(posedge clock) begin : check_results
      sorted_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_expect_q.size() == 0) begin
            note_error($sformatf("unexpected result %h last %b ovf %b",
                                 rsp_tdata, rsp_tlast, rsp_tuser[0]));
         end else begin
            want = sorted_expect_q.pop_front();
            if (rsp_tdata !== want.value || rsp_tlast !== want.final_res ||
                rsp_tuser[0] !== want.overflow)
               note_error($sformatf(
                  "expected %h last %b ovf %b, got %h last %b ovf %b",
                  want.value, want.final_res, want.overflow,
                  rsp_tdata, rsp_tlast, rsp_tuser[0]));
         end
      end
   end

   // Watchdog: too long without any beat moving means the engine hung
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Corner sets: single extremes, pairs, duplicates, zero and minus one
   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_beat(32'h7fff_ffff, 1'b1);
      send_beat(32'h8000_0000, 1'b1);
      send_beat(32'h7fff_ffff, 1'b0);
      send_beat(32'h8000_0000, 1'b1);
      send_beat(32'h8000_0000, 1'b0);
      send_beat(32'h7fff_ffff, 1'b1);
      send_beat(32'h0000_0000, 1'b0);
      send_beat(32'hffff_ffff, 1'b0);
      send_beat(32'h0000_0001, 1'b0);
      send_beat(32'hffff_ffff, 1'b0);
      send_beat(32'h7fff_ffff, 1'b0);
      send_beat(32'h8000_0000, 1'b1);
      // descending run with a repeated value
      send_beat(32'h0000_0004, 1'b0);
      send_beat(32'h0000_0003, 1'b0);
      send_beat(32'h0000_0003, 1'b0);
      send_beat(32'h0000_0001, 1'b0);
      send_beat(32'h0000_0000, 1'b1);
      drain();
   endtask

   // An exactly full set, then one that runs past capacity so that the
   // closing beat itself is dropped but still starts the sort
   task automatic test_full_and_overflow();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_set(CAPACITY);
      drain();
      send_idle_pct  = 20;
      recv_stall_pct = 20;
      send_set(CAPACITY + 2);
      drain();
   endtask

   // Random sets, mostly short, under one idle/stall mix
   task automatic test_random_sets(input int idle_pct, input int stall_pct,
                                   input int beat_budget);
      int sent;
      int count;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < beat_budget) begin
         count = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
         send_set(count);
         sent += count;
      end
      drain();
   endtask

   // Receiver holds off for a long stretch while input keeps coming,
   // so the engine fills and drops req_tready
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_rsp       = 1'b1;
      fork
         begin
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      repeat (6) send_set(4);
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_and_overflow();
      test_random_sets(0, 0, 10);
      test_random_sets(74, 0, 10);
      test_random_sets(0, 74, 10);
      test_random_sets(20, 20, 10);
      test_backpressure();

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && sorted_expect_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
hdl/hse_pkg.sv
hdl/hse_ram.sv
hdl/hse_ctrl.sv
hdl/heap_sort_engine.sv
bench/heap_sort_engine_tb.sv
